### rtl/hdlctx_pkg.sv
// Shared types, constants and the CRC-16 fold for the HDLC transmit framer.
// Used by the interfaces, the stuffing engine and the top level.
package hdlctx_pkg;

    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int RUN_W      = 3;
    localparam int HELD_W     = 3;
    localparam int FCS_W      = 16;
    // Held bits (up to 7) plus one stuffed byte (up to 10 bits)
    localparam int ACC_W      = 17;
    localparam int ACC_CNT_W  = 5;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [FCS_W-1:0]  CRC_POLY     = 16'h8408;
    localparam logic [FCS_W-1:0]  CRC_INIT     = 16'hFFFF;
    localparam logic [RUN_W-1:0]  STUFF_RUN    = 3'd5;
    localparam logic [BYTE_W-1:0] FLAG_PATTERN = 8'h7E;

    // Input item kinds; the fourth code is ignored
    typedef enum logic [KIND_W-1:0] {
        KIND_DATA  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_FLAG  = 2'd2
    } t_kind;

    // What the stuffing engine does with one symbol
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_STUFF = 2'd1,
        MODE_FLAG  = 2'd2
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [BYTE_W-1:0]  sym;
        logic [RUN_W-1:0]   run;
        logic [BYTE_W-1:0]  shifter;
        logic [HELD_W-1:0]  held;
    } t_eng_req;

    typedef struct packed {
        logic [1:0]         nbytes;
        logic [BYTE_W-1:0]  byte0;
        logic [BYTE_W-1:0]  byte1;
        logic [RUN_W-1:0]   run;
        logic [BYTE_W-1:0]  shifter;
        logic [HELD_W-1:0]  held;
    } t_eng_res;

    typedef struct packed {
        logic               last;
        logic [BYTE_W-1:0]  line_byte;
    } t_out_entry;

    // Fold one byte into the reflected CRC-16, LSB first
    function automatic logic [FCS_W-1:0] crc_fold(input logic [FCS_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] d);
        logic [FCS_W-1:0] c;
        c = crc ^ {{(FCS_W-BYTE_W){1'b0}}, d};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/hdlctx_if.sv
// Valid/ready channel interfaces for the HDLC transmit framer.
// Input channel carries kind and data byte; output channel carries line bytes.
interface hdlctx_in_if;
    logic                          valid;
    logic                          ready;
    logic [hdlctx_pkg::KIND_W-1:0] kind;
    logic [hdlctx_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface hdlctx_out_if;
    logic                          valid;
    logic                          ready;
    logic [hdlctx_pkg::BYTE_W-1:0] line_byte;
    logic                          last;

    modport source (output valid, output line_byte, output last, input ready);
    modport sink   (input valid, input line_byte, input last, output ready);
endinterface

### rtl/hdlctx_stuff_eng.sv
// Bit stuffing and byte packing for one symbol (stuffed byte or raw flag).
// Depends on hdlctx_pkg for the request and result structs.
module hdlctx_stuff_eng (
    input  hdlctx_pkg::t_eng_req i_req,
    output hdlctx_pkg::t_eng_res o_res
);
    import hdlctx_pkg::*;

    // Append the symbol's line bits after the held bits, then cut out full bytes
    always_comb begin
        logic [ACC_W-1:0]     w;
        logic [ACC_CNT_W-1:0] n;
        logic [RUN_W-1:0]     run;
        w   = ACC_W'(i_req.shifter);
        n   = ACC_CNT_W'(i_req.held);
        run = i_req.run;
        o_res = '0;
        case (i_req.mode)
            MODE_STUFF: begin
                for (int i = 0; i < BYTE_W; i++) begin
                    w = {w[ACC_W-2:0], i_req.sym[i]};
                    n = n + ACC_CNT_W'(1);
                    if (i_req.sym[i]) begin
                        run = run + RUN_W'(1);
                    end else begin
                        run = '0;
                    end
                    // Insert a zero after five ones in a row
                    if (run == STUFF_RUN) begin
                        w   = {w[ACC_W-2:0], 1'b0};
                        n   = n + ACC_CNT_W'(1);
                        run = '0;
                    end
                end
            end
            MODE_FLAG: begin
                w   = {w[ACC_W-BYTE_W-1:0], FLAG_PATTERN};
                n   = n + ACC_CNT_W'(BYTE_W);
                run = '0;
            end
            default: ;
        endcase

        if (n >= ACC_CNT_W'(2 * BYTE_W)) begin
            o_res.nbytes = 2'd2;
            o_res.byte0  = BYTE_W'(w >> (n - ACC_CNT_W'(BYTE_W)));
            o_res.byte1  = BYTE_W'(w >> (n - ACC_CNT_W'(2 * BYTE_W)));
        end else if (n >= ACC_CNT_W'(BYTE_W)) begin
            o_res.nbytes = 2'd1;
            o_res.byte0  = BYTE_W'(w >> (n - ACC_CNT_W'(BYTE_W)));
        end
        o_res.run     = run;
        o_res.shifter = w[BYTE_W-1:0];
        o_res.held    = n[HELD_W-1:0];
    end

endmodule

### rtl/hdlctx_out_fifo.sv
// Four-entry result queue that takes up to two line bytes a cycle.
// Depends on hdlctx_pkg and the output channel interface.
module hdlctx_out_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [1:0]                   i_push_n,
    input  hdlctx_pkg::t_out_entry       i_entry0,
    input  hdlctx_pkg::t_out_entry       i_entry1,
    output logic [hdlctx_pkg::FIFO_CW-1:0] o_count,
    hdlctx_out_if.source                 o_out
);
    import hdlctx_pkg::*;

    t_out_entry           r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_CW-1:0]   r_cnt;
    logic [FIFO_AW-1:0]   wr_next1;
    logic                 pop;

    assign wr_next1 = r_wr + FIFO_AW'(1);
    assign pop      = o_out.valid && o_out.ready;

    // Write up to two entries in order
    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr] <= i_entry0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wr_next1] <= i_entry1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + FIFO_AW'(i_push_n);
            r_rd  <= r_rd + FIFO_AW'(pop);
            r_cnt <= r_cnt + FIFO_CW'(i_push_n) - FIFO_CW'(pop);
        end
    end

    // Present the oldest entry
    assign o_out.valid     = (r_cnt != '0);
    assign o_out.line_byte = r_mem[r_rd].line_byte;
    assign o_out.last      = r_mem[r_rd].last;
    assign o_count         = r_cnt;

endmodule

### rtl/hdlc_tx_framer_crc16.sv
// HDLC transmit framer top level: CRC-16 (reflected 0x8408), bit stuffing and byte packing.
// Depends on hdlctx_pkg, hdlctx_if, hdlctx_stuff_eng and hdlctx_out_fifo.
//
// An accepted item is registered, then processed one symbol per cycle: a data byte or a
// flag is one symbol, a close is two (the low then the high byte of the complemented FCS).
// Each symbol yields zero, one or two line bytes into a four-entry queue, which drains
// one byte a cycle on the output channel while it is ready; a close yields up to three
// bytes. The stage advances only while the queue holds at most two bytes, and the input
// is ready again in the cycle its item finishes, so items stream back to back. Bits that
// do not fill a byte stay held for later items; last marks the final byte caused by an item.
module hdlc_tx_framer_crc16 (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hdlctx_in_if.sink     i_in,
    hdlctx_out_if.source  o_out
);
    import hdlctx_pkg::*;

    // Item stage
    logic               r_stg_vld;
    t_kind              r_stg_kind;
    logic [BYTE_W-1:0]  r_stg_data;
    logic               r_stg_phase;

    // Framer state
    logic [FCS_W-1:0]   r_fcs;
    logic [FCS_W-1:0]   n_fcs;
    logic [RUN_W-1:0]   r_run;
    logic [BYTE_W-1:0]  r_shifter;
    logic [HELD_W-1:0]  r_held;

    logic [FIFO_CW-1:0] fifo_count;
    logic               fifo_room;
    logic               fire;
    logic               stg_done;
    logic               sym_final;
    logic [FCS_W-1:0]   fcs_inv;
    logic               in_acc;
    t_eng_req           eng_req;
    t_eng_res           eng_res;
    logic [1:0]         push_n;
    t_out_entry         entry0;
    t_out_entry         entry1;

    assign fifo_room = (fifo_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign fire      = r_stg_vld && fifo_room;
    assign stg_done  = fire && ((r_stg_kind != KIND_CLOSE) || r_stg_phase);
    assign i_in.ready = !r_stg_vld || stg_done;
    assign in_acc    = i_in.valid && i_in.ready;
    assign fcs_inv   = ~r_fcs;

    // Hold the item; a close stays for a second symbol
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_vld   <= 1'b0;
            r_stg_phase <= 1'b0;
        end else if (in_acc) begin
            r_stg_vld   <= 1'b1;
            r_stg_phase <= 1'b0;
        end else if (stg_done) begin
            r_stg_vld   <= 1'b0;
        end else if (fire) begin
            r_stg_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_stg_kind <= t_kind'(i_in.kind);
            r_stg_data <= i_in.data_byte;
        end
    end

    // Select the symbol for the stuffing engine
    always_comb begin
        eng_req         = '0;
        eng_req.run     = r_run;
        eng_req.shifter = r_shifter;
        eng_req.held    = r_held;
        sym_final       = 1'b1;
        case (r_stg_kind)
            KIND_DATA: begin
                eng_req.mode = MODE_STUFF;
                eng_req.sym  = r_stg_data;
            end
            KIND_CLOSE: begin
                eng_req.mode = MODE_STUFF;
                eng_req.sym  = r_stg_phase ? fcs_inv[FCS_W-1:BYTE_W] : fcs_inv[BYTE_W-1:0];
                sym_final    = r_stg_phase;
            end
            KIND_FLAG: begin
                eng_req.mode = MODE_FLAG;
            end
            default: begin
                eng_req.mode = MODE_IDLE;
            end
        endcase
    end

    hdlctx_stuff_eng u_eng (
        .i_req (eng_req),
        .o_res (eng_res)
    );

    // Update CRC: fold data, restart after the closing FCS
    always_comb begin
        n_fcs = r_fcs;
        if (fire && (r_stg_kind == KIND_DATA)) begin
            n_fcs = crc_fold(r_fcs, r_stg_data);
        end else if (fire && (r_stg_kind == KIND_CLOSE) && r_stg_phase) begin
            n_fcs = CRC_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcs     <= CRC_INIT;
            r_run     <= '0;
            r_shifter <= '0;
            r_held    <= '0;
        end else begin
            r_fcs <= n_fcs;
            if (fire) begin
                r_run     <= eng_res.run;
                r_shifter <= eng_res.shifter;
                r_held    <= eng_res.held;
            end
        end
    end

    // Push finished bytes; tag the final byte of the item
    assign push_n           = fire ? eng_res.nbytes : 2'd0;
    assign entry0.line_byte = eng_res.byte0;
    assign entry0.last      = sym_final && (eng_res.nbytes == 2'd1);
    assign entry1.line_byte = eng_res.byte1;
    assign entry1.last      = sym_final;

    hdlctx_out_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_entry0 (entry0),
        .i_entry1 (entry1),
        .o_count  (fifo_count),
        .o_out    (o_out)
    );

`ifndef NO_ASSERTIONS
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("output queue overfilled");

    a_close_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (r_stg_kind == KIND_CLOSE) && !r_stg_phase) |=> (r_stg_vld && r_stg_phase))
        else $error("close did not continue with the high FCS byte");

    a_fcs_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (r_stg_kind == KIND_CLOSE) && r_stg_phase) |=> (r_fcs == CRC_INIT))
        else $error("CRC not restarted after close");

    a_close_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (r_stg_kind == KIND_CLOSE) && r_stg_phase) |-> (eng_res.nbytes != 2'd0))
        else $error("close finished without a final byte");
`endif

endmodule
